[design/uoe_pkg.sv]
// shared types and constants for the undocumented opcode execute unit
`timescale 1ns / 1ps

package uoe_pkg;

   typedef enum logic [4:0] {
      OP_SLO = 5'd0,
      OP_RLA = 5'd1,
      OP_SRE = 5'd2,
      OP_RRA = 5'd3,
      OP_SAX = 5'd4,
      OP_LAX = 5'd5,
      OP_DCP = 5'd6,
      OP_ISC = 5'd7,
      OP_ANC = 5'd8,
      OP_ALR = 5'd9,
      OP_ARR = 5'd10,
      OP_XAA = 5'd11,
      OP_AXS = 5'd12,
      OP_AHX = 5'd13,
      OP_SHY = 5'd14,
      OP_SHX = 5'd15,
      OP_TAS = 5'd16,
      OP_LAS = 5'd17
   } op_type;

   // status bit positions
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_D = 3;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   // low bit of the address high byte
   localparam int ADDR_HI_LSB = 8;

   typedef struct packed {
      logic [4:0]  operation;
      logic [15:0] operand_addr;
      logic [7:0]  mem_data;
      logic [7:0]  reg_a;
      logic [7:0]  reg_x;
      logic [7:0]  reg_y;
      logic [7:0]  reg_s;
      logic [7:0]  status_in;
   } req_type;

   typedef struct packed {
      logic [7:0] new_a;
      logic [7:0] new_x;
      logic [7:0] new_s;
      logic [7:0] status_out;
      logic       store_enable;
      logic [7:0] store_data;
      logic       rmw_dummy;
   } rsp_type;

   typedef struct packed {
      logic n;
      logic v;
      logic z;
      logic c;
   } nvzc_type;

endpackage

[design/undocumented_opcode_execute.sv]
// top level: request register, opcode datapath and result register
// a request is held in the request register, then its result in the result register, before its strobe rises
// throughput: one request per cycle; busy never rises, since the datapath is combinational
// results are strobed for one cycle and the receiver cannot stall them
// reset (synchronous, active high) clears the request and result valid flags
`timescale 1ns / 1ps

module undocumented_opcode_execute
   import uoe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_operation,
   input  logic [15:0] req_operand_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [7:0]  req_reg_a,
   input  logic [7:0]  req_reg_x,
   input  logic [7:0]  req_reg_y,
   input  logic [7:0]  req_reg_s,
   input  logic [7:0]  req_status_in,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_new_a,
   output logic [7:0]  rsp_new_x,
   output logic [7:0]  rsp_new_s,
   output logic [7:0]  rsp_status_out,
   output logic        rsp_store_enable,
   output logic [7:0]  rsp_store_data,
   output logic        rsp_rmw_dummy
);

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   req_type req_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   assign req_in.operation    = req_operation;
   assign req_in.operand_addr = req_operand_addr;
   assign req_in.mem_data     = req_mem_data;
   assign req_in.reg_a        = req_reg_a;
   assign req_in.reg_x        = req_reg_x;
   assign req_in.reg_y        = req_reg_y;
   assign req_in.reg_s        = req_reg_s;
   assign req_in.status_in    = req_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   uoe_alu u_alu (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_new_a        = rsp_ff.new_a;
   assign rsp_new_x        = rsp_ff.new_x;
   assign rsp_new_s        = rsp_ff.new_s;
   assign rsp_status_out   = rsp_ff.status_out;
   assign rsp_store_enable = rsp_ff.store_enable;
   assign rsp_store_data   = rsp_ff.store_data;
   assign rsp_rmw_dummy    = rsp_ff.rmw_dummy;

endmodule

[design/uoe_addsub.sv]
// adc / sbc adder with nmos decimal mode
`timescale 1ns / 1ps

module uoe_addsub
   import uoe_pkg::*;
(
   input  logic [7:0] a,
   input  logic [7:0] b,
   input  logic       carry_in,
   input  logic       decimal,
   input  logic       subtract,
   output logic [7:0] sum,
   output nvzc_type   flags
);

   logic [7:0] b_eff;
   logic [8:0] bin;
   logic [5:0] adc_lo;
   logic [4:0] adc_hi;
   logic [5:0] adc_hi_adj;
   logic [4:0] sbc_lo;
   logic [4:0] sbc_hi;
   logic [3:0] sbc_lo_adj;
   logic [3:0] sbc_hi_adj;

   assign b_eff = subtract ? ~b : b;
   assign bin   = {1'b0, a} + {1'b0, b_eff} + {8'd0, carry_in};

   // decimal add: digit carry from the adjusted low digit
   always_comb begin
      adc_lo = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, carry_in};
      if (adc_lo > 6'd9) begin
         adc_lo = adc_lo + 6'd6;
      end
      adc_hi = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'd0, (adc_lo > 6'd15)};
      // high digit can reach 31 on non-decimal digits, so keep room for the adjust
      adc_hi_adj = (adc_hi > 5'd9) ? {1'b0, adc_hi} + 6'd6 : {1'b0, adc_hi};
   end

   // decimal subtract: digit borrows taken from bit 4
   always_comb begin
      sbc_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ~carry_in};
      sbc_lo_adj = sbc_lo[4] ? sbc_lo[3:0] - 4'd6 : sbc_lo[3:0];
      sbc_hi = {1'b0, a[7:4]} - {1'b0, b[7:4]} - {4'd0, sbc_lo[4]};
      sbc_hi_adj = sbc_hi[4] ? sbc_hi[3:0] - 4'd6 : sbc_hi[3:0];
   end

   always_comb begin
      flags.z = (bin[7:0] == 8'd0);
      if (decimal && !subtract) begin
         sum     = {adc_hi_adj[3:0], adc_lo[3:0]};
         flags.n = adc_hi[3];
         flags.v = ~(a[7] ^ b[7]) & (a[7] ^ adc_hi[3]);
         flags.c = (adc_hi_adj > 6'd15);
      end else begin
         sum     = (decimal && subtract) ? {sbc_hi_adj, sbc_lo_adj} : bin[7:0];
         flags.n = bin[7];
         flags.v = ~(a[7] ^ b_eff[7]) & (a[7] ^ bin[7]);
         flags.c = bin[8];
      end
   end

endmodule

[design/uoe_alu.sv]
// combinational datapath for one undocumented opcode
`timescale 1ns / 1ps

module uoe_alu
   import uoe_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   op_type     op;
   logic [7:0] m;
   logic [7:0] a;
   logic [7:0] x;
   logic [7:0] p;
   logic [7:0] hi;
   logic [7:0] asl_m;
   logic [7:0] rol_m;
   logic [7:0] lsr_m;
   logic [7:0] ror_m;
   logic [7:0] dec_m;
   logic [7:0] inc_m;
   logic [7:0] and_am;
   logic [7:0] and_ax;
   logic [7:0] las_v;
   logic [7:0] res;
   logic [8:0] cmp_diff;
   logic [7:0] cmp_r;
   logic [7:0] cmp_v;
   logic [7:0] as_b;
   logic       as_cin;
   logic [7:0] as_sum;
   nvzc_type   as_flags;

   assign op     = op_type'(req.operation);
   assign m      = req.mem_data;
   assign a      = req.reg_a;
   assign x      = req.reg_x;
   assign p      = req.status_in;
   assign hi     = req.operand_addr[ADDR_HI_LSB +: 8];
   assign asl_m  = {m[6:0], 1'b0};
   assign rol_m  = {m[6:0], p[FLAG_C]};
   assign lsr_m  = {1'b0, m[7:1]};
   assign ror_m  = {p[FLAG_C], m[7:1]};
   assign dec_m  = m - 8'd1;
   assign inc_m  = m + 8'd1;
   assign and_am = a & m;
   assign and_ax = a & x;
   assign las_v  = req.reg_s & m;

   // shared compare for dcp and axs
   assign cmp_r    = (op == OP_AXS) ? and_ax : a;
   assign cmp_v    = (op == OP_AXS) ? m : dec_m;
   assign cmp_diff = {1'b0, cmp_r} - {1'b0, cmp_v};

   // rra adds with the carry out of its ror, isc subtracts with the old carry
   assign as_b   = (op == OP_RRA) ? ror_m : inc_m;
   assign as_cin = (op == OP_RRA) ? m[0] : p[FLAG_C];

   uoe_addsub u_addsub (
      .a        (a),
      .b        (as_b),
      .carry_in (as_cin),
      .decimal  (p[FLAG_D]),
      .subtract (op == OP_ISC),
      .sum      (as_sum),
      .flags    (as_flags)
   );

   always_comb begin
      rsp.new_a        = a;
      rsp.new_x        = x;
      rsp.new_s        = req.reg_s;
      rsp.status_out   = p;
      rsp.store_enable = 1'b0;
      rsp.store_data   = 8'd0;
      rsp.rmw_dummy    = 1'b0;
      res              = 8'd0;
      case (op)
         OP_SLO: begin
            res                     = a | asl_m;
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = m[7];
            rsp.store_enable        = 1'b1;
            rsp.store_data          = asl_m;
            rsp.rmw_dummy           = 1'b1;
         end
         OP_RLA: begin
            res                     = a & rol_m;
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = m[7];
            rsp.store_enable        = 1'b1;
            rsp.store_data          = rol_m;
            rsp.rmw_dummy           = 1'b1;
         end
         OP_SRE: begin
            res                     = a ^ lsr_m;
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = m[0];
            rsp.store_enable        = 1'b1;
            rsp.store_data          = lsr_m;
            rsp.rmw_dummy           = 1'b1;
         end
         OP_RRA, OP_ISC: begin
            rsp.new_a               = as_sum;
            rsp.status_out[FLAG_N]  = as_flags.n;
            rsp.status_out[FLAG_V]  = as_flags.v;
            rsp.status_out[FLAG_Z]  = as_flags.z;
            rsp.status_out[FLAG_C]  = as_flags.c;
            rsp.store_enable        = 1'b1;
            rsp.store_data          = (op == OP_RRA) ? ror_m : inc_m;
            rsp.rmw_dummy           = 1'b1;
         end
         OP_SAX: begin
            rsp.store_enable        = 1'b1;
            rsp.store_data          = and_ax;
         end
         OP_LAX: begin
            res                     = m;
            rsp.new_a               = m;
            rsp.new_x               = m;
         end
         OP_DCP, OP_AXS: begin
            rsp.status_out[FLAG_N]  = cmp_diff[7];
            rsp.status_out[FLAG_Z]  = (cmp_diff[7:0] == 8'd0);
            rsp.status_out[FLAG_C]  = ~cmp_diff[8];
            if (op == OP_DCP) begin
               rsp.store_enable     = 1'b1;
               rsp.store_data       = dec_m;
               rsp.rmw_dummy        = 1'b1;
            end else begin
               rsp.new_x            = cmp_diff[7:0];
            end
         end
         OP_ANC: begin
            res                     = and_am;
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = and_am[7];
         end
         OP_ALR: begin
            res                     = {1'b0, and_am[7:1]};
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = and_am[0];
         end
         OP_ARR: begin
            res                     = {p[FLAG_C], and_am[7:1]};
            rsp.new_a               = res;
            rsp.status_out[FLAG_C]  = and_am[0];
         end
         OP_XAA: begin
            res                     = x & m;
            rsp.new_a               = res;
         end
         OP_AHX: begin
            rsp.store_enable        = 1'b1;
            rsp.store_data          = and_ax & hi;
         end
         OP_SHY: begin
            rsp.store_enable        = 1'b1;
            rsp.store_data          = req.reg_y & hi;
         end
         OP_SHX: begin
            rsp.store_enable        = 1'b1;
            rsp.store_data          = x & hi;
         end
         OP_TAS: begin
            rsp.new_s               = and_ax;
            rsp.store_enable        = 1'b1;
            rsp.store_data          = and_ax & hi;
         end
         OP_LAS: begin
            res                     = las_v;
            rsp.new_a               = las_v;
            rsp.new_x               = las_v;
            rsp.new_s               = las_v;
         end
         default: begin
         end
      endcase
      // common nz update from the logic result
      if (op == OP_SLO || op == OP_RLA || op == OP_SRE || op == OP_LAX ||
          op == OP_ANC || op == OP_ALR || op == OP_ARR || op == OP_XAA ||
          op == OP_LAS) begin
         rsp.status_out[FLAG_N] = res[7];
         rsp.status_out[FLAG_Z] = (res == 8'd0);
      end
   end

endmodule
